/* src/can_filter_bank_packer_assert.svh */
// Assertion macros shared by the filter bank packer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef CAN_FILTER_BANK_PACKER_ASSERT_SVH
`define CAN_FILTER_BANK_PACKER_ASSERT_SVH

// Checks that a property holds at every rising edge outside reset.
`define CFBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition holds whenever a result item is shown.
`define CFBP_ASSERT_RESULT(name, cond, msg) \
  `CFBP_ASSERT(name, result_valid |-> (cond), msg)

`endif

/* src/cfbp_pkg.sv */
// Package for the CAN filter bank packer: widths, register indexes and
// word-building helpers. No dependencies.
package cfbp_pkg;

  localparam int NUM_BANKS_DEF = 28;
  localparam int BANK_W        = 5;
  localparam int MAP_W         = 28;
  localparam int IDENT_W       = 29;
  localparam int WORD_W        = 32;
  localparam int HALF_W        = 16;
  localparam int EN_W          = 2;
  localparam int SLOT_W        = 2;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam int REG_IDX_W     = 1;

  localparam logic [BANK_W-1:0]    SLAVE_START_RST = 5'd14;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_CTRL = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SLAVE_START = 1'b1;

  localparam logic [EN_W-1:0] EN_NONE = 2'b00;
  localparam logic [EN_W-1:0] EN_LOW  = 2'b01;
  localparam logic [EN_W-1:0] EN_HIGH = 2'b10;
  localparam logic [EN_W-1:0] EN_BOTH = 2'b11;

  // Quad slot codes: count of 11-bit list entries still free in the open bank.
  localparam logic [SLOT_W-1:0] QUAD_W1_HIGH = 2'd3;
  localparam logic [SLOT_W-1:0] QUAD_W2_LOW  = 2'd2;
  localparam logic [SLOT_W-1:0] QUAD_W2_HIGH = 2'd1;
  localparam logic [SLOT_W-1:0] QUAD_NONE    = 2'd0;

  // 32-bit scale word: identifier, IDE set, RTR.
  function automatic logic [WORD_W-1:0] long_word(input logic [IDENT_W-1:0] id,
                                                   input logic rtr_bit);
    return {id, 1'b1, rtr_bit, 1'b0};
  endfunction

  // 16-bit scale half word: 11-bit identifier, RTR, IDE and extension bits clear.
  function automatic logic [HALF_W-1:0] short_half(input logic [IDENT_W-1:0] id,
                                                   input logic rtr_bit);
    return {id[10:0], rtr_bit, 4'b0000};
  endfunction

endpackage

/* src/can_filter_bank_packer.sv */
// Top level of the CAN acceptance filter bank packer.
// Depends on cfbp_pkg; checked by cfbp_checker through a bind.
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  -----------------------------------------
//  item      item_valid / item_ready    first_of_list extended masked ident
//                                       ident_mask rtr rtr_compare
//  result    result_valid/result_ready  stored bank word_one word_one_enables
//                                       word_two word_two_enables scale_map
//                                       mode_map active_map
//  config    APB psel/penable/pwrite    paddr pwdata prdata, pready tied high
//
// Placement, word building and map updates are computed straight from the item
// ports and land in the result register at the edge that accepts the item, so
// one item per cycle is sustained while no result waits unclaimed. The result
// register is the only stage; item_ready drops only while a result waits
// unclaimed. Reset is synchronous and clears the cursor, the pending slots,
// the bank maps and the result valid flag; configuration returns to first
// controller with the split at bank 14.
module can_filter_bank_packer
  import cfbp_pkg::*;
#(
  parameter int NUM_BANKS = NUM_BANKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Filter items.
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 first_of_list,
  input  logic                 extended,
  input  logic                 masked,
  input  logic [IDENT_W-1:0]   ident,
  input  logic [IDENT_W-1:0]   ident_mask,
  input  logic                 rtr,
  input  logic                 rtr_compare,
  // Result items.
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic                 stored,
  output logic [BANK_W-1:0]    bank,
  output logic [WORD_W-1:0]    word_one,
  output logic [EN_W-1:0]      word_one_enables,
  output logic [WORD_W-1:0]    word_two,
  output logic [EN_W-1:0]      word_two_enables,
  output logic [MAP_W-1:0]     scale_map,
  output logic [MAP_W-1:0]     mode_map,
  output logic [MAP_W-1:0]     active_map,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  // The cursor must hold both any start bank and the end of the range itself.
  localparam int CUR_W = ($clog2(NUM_BANKS + 1) > BANK_W) ? $clog2(NUM_BANKS + 1) : BANK_W;
  localparam logic [CUR_W-1:0] NB_CUR = CUR_W'(NUM_BANKS);

  // Configuration registers.
  logic                  second_controller;
  logic [BANK_W-1:0]     slave_start_bank;

  // Packing state.
  logic [CUR_W-1:0]      cursor, cursor_next;
  logic                  long_list_pending, long_list_pending_next;
  logic [BANK_W-1:0]     long_list_bank, long_list_bank_next;
  logic                  short_mask_pending, short_mask_pending_next;
  logic [BANK_W-1:0]     short_mask_bank, short_mask_bank_next;
  logic [SLOT_W-1:0]     short_list_left, short_list_left_next;
  logic [BANK_W-1:0]     short_list_bank, short_list_bank_next;
  logic [NUM_BANKS-1:0]  scale_bits, scale_bits_next;
  logic [NUM_BANKS-1:0]  mode_bits, mode_bits_next;
  logic [NUM_BANKS-1:0]  active_bits, active_bits_next;

  // Result values for the accepted item.
  logic                  stored_next;
  logic [BANK_W-1:0]     bank_next;
  logic [WORD_W-1:0]     word_one_next, word_two_next;
  logic [EN_W-1:0]       word_one_enables_next, word_two_enables_next;

  logic                  accept;
  logic                  cfg_write;
  logic [REG_IDX_W-1:0]  reg_idx;

  logic [CUR_W-1:0]      range_start, range_end, cur_eff;
  logic [NUM_BANKS-1:0]  low_banks, bank_onehot, active_base;
  logic [WORD_W-1:0]     low_full;
  logic [WORD_W-1:0]     long_id, long_mask;
  logic [HALF_W-1:0]     short_id;
  logic [WORD_W-1:0]     short_pair;

  // A new item is taken whenever the result register is empty or being drained.
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  // ---------------------------------------------------------------------------
  // APB configuration. Registers sit on word addresses; pready is always high.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_controller <= 1'b0;
      slave_start_bank  <= SLAVE_START_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_SECOND_CTRL: second_controller <= pwdata[0];
        REG_SLAVE_START: slave_start_bank  <= pwdata[BANK_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SECOND_CTRL: prdata = PDATA_W'(second_controller);
      REG_SLAVE_START: prdata = PDATA_W'(slave_start_bank);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Bank range of this controller. The first controller stops at the split or
  // at the last bank, whichever comes first; the second runs to the last bank
  // and is empty when the split lies beyond it.
  // ---------------------------------------------------------------------------
  always_comb begin
    range_start = second_controller ? CUR_W'(slave_start_bank) : '0;
    if (!second_controller && (CUR_W'(slave_start_bank) < NB_CUR)) begin
      range_end = CUR_W'(slave_start_bank);
    end else begin
      range_end = NB_CUR;
    end
  end

  // Banks below the split; a new list clears the active bits of its own side.
  assign low_full  = (WORD_W'(1) << slave_start_bank) - WORD_W'(1);
  assign low_banks = low_full[NUM_BANKS-1:0];

  always_comb begin
    if (first_of_list) begin
      active_base = second_controller ? (active_bits & low_banks)
                                      : (active_bits & ~low_banks);
    end else begin
      active_base = active_bits;
    end
  end

  // Filter words in both scales.
  assign long_id    = long_word(ident, rtr);
  assign long_mask  = long_word(ident_mask, rtr_compare);
  assign short_id   = short_half(ident, rtr);
  assign short_pair = {short_half(ident_mask, rtr_compare), short_id};

  assign cur_eff     = first_of_list ? range_start : cursor;
  // Shifting past the top leaves no bit set, so a stray bank touches no map.
  assign bank_onehot = NUM_BANKS'(1) << bank_next;

  // ---------------------------------------------------------------------------
  // Placement. A new list restarts the cursor and forgets every half-filled
  // bank before this item is placed. Once the cursor reaches the range end the
  // item is dropped, even if a shared bank still has room.
  // ---------------------------------------------------------------------------
  always_comb begin
    cursor_next             = cur_eff;
    long_list_pending_next  = first_of_list ? 1'b0 : long_list_pending;
    long_list_bank_next     = long_list_bank;
    short_mask_pending_next = first_of_list ? 1'b0 : short_mask_pending;
    short_mask_bank_next    = short_mask_bank;
    short_list_left_next    = first_of_list ? QUAD_NONE : short_list_left;
    short_list_bank_next    = short_list_bank;

    stored_next           = 1'b0;
    bank_next             = '0;
    word_one_next         = '0;
    word_one_enables_next = EN_NONE;
    word_two_next         = '0;
    word_two_enables_next = EN_NONE;

    if (cur_eff < range_end) begin
      stored_next = 1'b1;
      if (extended) begin
        if (masked) begin
          // Identifier and mask fill a whole bank.
          bank_next             = BANK_W'(cur_eff);
          word_one_next         = long_id;
          word_one_enables_next = EN_BOTH;
          word_two_next         = long_mask;
          word_two_enables_next = EN_BOTH;
          cursor_next           = cur_eff + CUR_W'(1);
        end else if (long_list_pending_next) begin
          // Second identifier of a list pair goes to word two.
          bank_next              = long_list_bank;
          word_two_next          = long_id;
          word_two_enables_next  = EN_BOTH;
          long_list_pending_next = 1'b0;
        end else begin
          // Open a list pair; both words carry the identifier until paired.
          bank_next              = BANK_W'(cur_eff);
          long_list_bank_next    = BANK_W'(cur_eff);
          word_one_next          = long_id;
          word_one_enables_next  = EN_BOTH;
          word_two_next          = long_id;
          word_two_enables_next  = EN_BOTH;
          long_list_pending_next = 1'b1;
          cursor_next            = cur_eff + CUR_W'(1);
        end
      end else if (masked) begin
        if (short_mask_pending_next) begin
          bank_next               = short_mask_bank;
          word_two_next           = short_pair;
          word_two_enables_next   = EN_BOTH;
          short_mask_pending_next = 1'b0;
        end else begin
          bank_next               = BANK_W'(cur_eff);
          short_mask_bank_next    = BANK_W'(cur_eff);
          word_one_next           = short_pair;
          word_one_enables_next   = EN_BOTH;
          word_two_next           = short_pair;
          word_two_enables_next   = EN_BOTH;
          short_mask_pending_next = 1'b1;
          cursor_next             = cur_eff + CUR_W'(1);
        end
      end else if (short_list_left_next != QUAD_NONE) begin
        // Fill the next free quarter of an open quad bank.
        bank_next = short_list_bank;
        unique case (short_list_left_next)
          QUAD_W1_HIGH: begin
            word_one_next         = {short_id, HALF_W'(0)};
            word_one_enables_next = EN_HIGH;
          end
          QUAD_W2_LOW: begin
            word_two_next         = WORD_W'(short_id);
            word_two_enables_next = EN_LOW;
          end
          default: begin
            word_two_next         = {short_id, HALF_W'(0)};
            word_two_enables_next = EN_HIGH;
          end
        endcase
        short_list_left_next = short_list_left_next - SLOT_W'(1);
      end else begin
        // Open a quad bank with the identifier in all four quarters.
        bank_next             = BANK_W'(cur_eff);
        short_list_bank_next  = BANK_W'(cur_eff);
        word_one_next         = {short_id, short_id};
        word_one_enables_next = EN_BOTH;
        word_two_next         = {short_id, short_id};
        word_two_enables_next = EN_BOTH;
        short_list_left_next  = QUAD_W1_HIGH;
        cursor_next           = cur_eff + CUR_W'(1);
      end
    end
  end

  // Bank maps after the placement.
  always_comb begin
    scale_bits_next  = scale_bits;
    mode_bits_next   = mode_bits;
    active_bits_next = active_base;
    if (stored_next) begin
      scale_bits_next  = extended ? (scale_bits | bank_onehot) : (scale_bits & ~bank_onehot);
      mode_bits_next   = masked ? (mode_bits & ~bank_onehot) : (mode_bits | bank_onehot);
      active_bits_next = active_base | bank_onehot;
    end
  end

  // ---------------------------------------------------------------------------
  // State and result registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor             <= '0;
      long_list_pending  <= 1'b0;
      long_list_bank     <= '0;
      short_mask_pending <= 1'b0;
      short_mask_bank    <= '0;
      short_list_left    <= QUAD_NONE;
      short_list_bank    <= '0;
      scale_bits         <= '0;
      mode_bits          <= '0;
      active_bits        <= '0;
    end else if (accept) begin
      cursor             <= cursor_next;
      long_list_pending  <= long_list_pending_next;
      long_list_bank     <= long_list_bank_next;
      short_mask_pending <= short_mask_pending_next;
      short_mask_bank    <= short_mask_bank_next;
      short_list_left    <= short_list_left_next;
      short_list_bank    <= short_list_bank_next;
      scale_bits         <= scale_bits_next;
      mode_bits          <= mode_bits_next;
      active_bits        <= active_bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload; the maps are widened to a word, then cut to the port width.
  always_ff @(posedge clk) begin
    if (accept) begin
      stored           <= stored_next;
      bank             <= bank_next;
      word_one         <= word_one_next;
      word_one_enables <= word_one_enables_next;
      word_two         <= word_two_next;
      word_two_enables <= word_two_enables_next;
      scale_map        <= MAP_W'(WORD_W'(scale_bits_next));
      mode_map         <= MAP_W'(WORD_W'(mode_bits_next));
      active_map       <= MAP_W'(WORD_W'(active_bits_next));
    end
  end

endmodule

/* src/cfbp_checker.sv */
// Port-level checker for the CAN filter bank packer, bound to the top level.
// Depends on cfbp_pkg and can_filter_bank_packer_assert.svh.
`include "can_filter_bank_packer_assert.svh"

module cfbp_checker
  import cfbp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic               stored,
  input logic [BANK_W-1:0]  bank,
  input logic [WORD_W-1:0]  word_one,
  input logic [EN_W-1:0]    word_one_enables,
  input logic [WORD_W-1:0]  word_two,
  input logic [EN_W-1:0]    word_two_enables,
  input logic [MAP_W-1:0]   active_map
);

  // A dropped filter writes nothing.
  `CFBP_ASSERT_RESULT(a_drop_quiet, !stored |-> (bank == '0 && word_one_enables == EN_NONE && word_two_enables == EN_NONE), "dropped item carries a write")

  // A word that is not written carries zero.
  `CFBP_ASSERT_RESULT(a_idle_word_zero, (word_one_enables != EN_NONE || word_one == '0) && (word_two_enables != EN_NONE || word_two == '0), "unwritten word is not zero")

  // A placed filter leaves its bank active.
  `CFBP_ASSERT_RESULT(a_bank_active, (stored && bank < BANK_W'(MAP_W)) |-> (((active_map >> bank) & MAP_W'(1)) != '0), "written bank is not active")

  // Intake stalls only behind an unclaimed result.
  `CFBP_ASSERT(a_stall_cause, !item_ready |-> (result_valid && !result_ready), "item stalled with room")

  // A stalled result stays shown.
  `CFBP_ASSERT(a_result_holds, (result_valid && !result_ready) |=> result_valid, "result dropped while stalled")

endmodule

bind can_filter_bank_packer cfbp_checker u_cfbp_checker (.*);
